>>> src/urlpd_pkg.sv
package urlpd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam int unsigned HEX_BASE  = 16;
	localparam int unsigned NIB_W     = $clog2(HEX_BASE);

	// Escape progress. The fourth code is never entered and decodes as idle.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HELD = 2'd2
	} phase_t;

	// One decoded byte with its framing marks.
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       string_end;
	} res_t;

	// What one input item produces: zero, one or two results.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} dec_t;

	// Hex digit value with a flag that says whether the character is a hex digit.
	typedef struct packed {
		logic             ok;
		logic [NIB_W-1:0] value;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok    = 1'b1;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = NIB_W'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = NIB_W'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = NIB_W'(c - 8'h61 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [7:0] plain_char(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

>>> src/urlpd_decode.sv
module urlpd_decode (
	input  urlpd_pkg::phase_t phase,
	input  logic [7:0]        held,
	input  logic [7:0]        cur_byte,
	input  logic              cur_last,
	output urlpd_pkg::phase_t phase_next,
	output logic [7:0]        held_next,
	output urlpd_pkg::dec_t   dec
);
	import urlpd_pkg::*;

	hex_t hi;
	hex_t lo;

	assign hi = hex_value(held);
	assign lo = hex_value(cur_byte);

	// Next escape state and held character.
	always_comb begin
		phase_next = PH_IDLE;
		held_next  = held;
		unique case (phase)
			PH_PCT: begin
				if (cur_last) begin
					held_next = '0;
				end else begin
					phase_next = PH_HELD;
					held_next  = cur_byte;
				end
			end
			PH_HELD: begin
				held_next = '0;
			end
			default: begin
				if (cur_byte == CH_PERCENT && !cur_last) begin
					phase_next = PH_PCT;
				end
			end
		endcase
	end

	// Results of the current character.
	always_comb begin
		dec.count         = 2'd1;
		dec.r0.data       = plain_char(cur_byte);
		dec.r0.run_last   = 1'b1;
		dec.r0.string_end = cur_last;
		dec.r1.data       = plain_char(cur_byte);
		dec.r1.run_last   = 1'b1;
		dec.r1.string_end = 1'b1;
		unique case (phase)
			PH_PCT: begin
				if (cur_last) begin
					dec.count         = 2'd2;
					dec.r0.data       = CH_PERCENT;
					dec.r0.run_last   = 1'b0;
					dec.r0.string_end = 1'b0;
				end else begin
					dec.count = 2'd0;
				end
			end
			PH_HELD: begin
				if (!hi.ok) begin
					dec.r0.data = '0;
				end else if (lo.ok) begin
					dec.r0.data = {hi.value, lo.value};
				end else begin
					dec.r0.data = {{(8 - NIB_W){1'b0}}, hi.value};
				end
			end
			default: begin
				if (cur_byte == CH_PERCENT && !cur_last) begin
					dec.count = 2'd0;
				end
			end
		endcase
	end

endmodule

>>> src/url_percent_decoder_core.sv
// Streaming URL percent-decoder. Characters of an encoded string arrive one item
// per clock on in_byte while in_stall is low, with in_last set on the final
// character. A '+' becomes a space, a '%' with the two characters after it
// becomes one byte (the value of the leading one or two hex digits, or zero if
// the first is not a hex digit), and every other character passes unchanged.
// An item is held in the input register and its results leave through a
// two-entry result queue, whose head entry drives the output. A new item is
// taken in every cycle as long as the consumer keeps up: items inside an escape
// produce no result, most produce one, and a string that ends one character
// after a '%' produces two ('%' and then that character). Such an item waits
// in the input register until both queue entries are free, and stalls the
// input meanwhile. On each result run_last marks the last result of its item
// and string_end marks the final byte of the string. Reset clears the escape
// state; no setup is needed.
module url_percent_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);
	import urlpd_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Escape state.
	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     phase_next;
	logic [7:0] held_next;
	dec_t       dec;

	// Result queue: entry 0 is the head shown on the output.
	res_t       ent0_q;
	res_t       ent1_q;
	logic [1:0] cnt_q;
	res_t       ent0_next;
	res_t       ent1_next;
	logic [1:0] cnt_next;
	logic [1:0] cnt_after_pop;
	logic [1:0] free_slots;
	logic       pop;
	logic       advance;
	logic       load_s1;

	urlpd_decode u_decode (
		.phase      (phase_q),
		.held       (held_q),
		.cur_byte   (byte_s1),
		.cur_last   (last_s1),
		.phase_next (phase_next),
		.held_next  (held_next),
		.dec        (dec)
	);

	assign out_valid  = (cnt_q != 2'd0);
	assign out_byte   = ent0_q.data;
	assign run_last   = ent0_q.run_last;
	assign string_end = ent0_q.string_end;

	assign pop        = out_valid && !out_stall;
	// The queue never holds more than two entries, so this never wraps.
	assign free_slots = 2'd2 - cnt_q + {1'b0, pop};
	// The registered item moves on only if all of its results fit in the queue.
	assign advance    = valid_s1 && (dec.count <= free_slots);
	assign in_stall   = valid_s1 && !advance;
	assign load_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_next;
			held_q  <= held_next;
		end
	end

	// Queue update: drop the head if it was taken, then append the new results
	// behind whatever remains.
	always_comb begin
		ent0_next     = ent0_q;
		ent1_next     = ent1_q;
		cnt_after_pop = cnt_q;
		if (pop) begin
			ent0_next     = ent1_q;
			cnt_after_pop = cnt_q - 2'd1;
		end
		cnt_next = cnt_after_pop;
		if (advance) begin
			cnt_next = cnt_after_pop + dec.count;
			if (dec.count != 2'd0) begin
				if (cnt_after_pop == 2'd0) begin
					ent0_next = dec.r0;
				end else begin
					ent1_next = dec.r0;
				end
			end
			if (dec.count == 2'd2) begin
				ent1_next = dec.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		ent0_q <= ent0_next;
		ent1_q <= ent1_next;
	end

`ifndef NO_ASSERTIONS
	// The result queue holds at most two entries.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue overflow");

	// The held character is cleared whenever no escape is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> held_q == 8'd0)
		else $error("held character left over outside an escape");

	// A blocked item keeps its place and contents in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a blocked item");

	// The final byte of a string is always the last result of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string end without run end");
`endif

endmodule

>>> tb/sv/urlpd_decode_monitor.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder. It computes the expected output for
// every accepted input item and compares each accepted output item with the
// oldest expected one.
module urlpd_decode_monitor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       string_end,
	output int         fail_count,
	output int         pending_count
);
	import urlpd_pkg::*;

	res_t       decoded_q[$];
	phase_t     esc_phase;
	logic [7:0] held_byte;
	int         mismatches  = 0;
	int         outstanding = 0;

	assign fail_count    = mismatches;
	assign pending_count = outstanding;

	// Bit 4 says whether the character is a hex digit; bits 3:0 hold its value.
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, c[3:0]};
		if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
			return {1'b1, 4'(c[3:0] + 4'd9)};
		return 5'd0;
	endfunction

	function automatic logic [7:0] unescaped(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	function automatic res_t make_res(input logic [7:0] b, input logic rl, input logic se);
		res_t r;
		r.data       = b;
		r.run_last   = rl;
		r.string_end = se;
		return r;
	endfunction

	task automatic decode_expected(input logic [7:0] c, input logic last);
		logic [4:0] hi;
		logic [4:0] lo;
		logic [7:0] value;
		case (esc_phase)
			PH_PCT: begin
				if (last) begin
					decoded_q.push_back(make_res(CH_PERCENT, 1'b0, 1'b0));
					decoded_q.push_back(make_res(unescaped(c), 1'b1, 1'b1));
					esc_phase = PH_IDLE;
					held_byte = 8'd0;
				end else begin
					held_byte = c;
					esc_phase = PH_HELD;
				end
			end
			PH_HELD: begin
				hi    = digit_of(held_byte);
				lo    = digit_of(c);
				value = 8'd0;
				if (hi[4])
					value = lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]};
				decoded_q.push_back(make_res(value, 1'b1, last));
				esc_phase = PH_IDLE;
				held_byte = 8'd0;
			end
			default: begin
				esc_phase = PH_IDLE;
				if (c == CH_PERCENT && !last)
					esc_phase = PH_PCT;
				else
					decoded_q.push_back(make_res(unescaped(c), 1'b1, last));
			end
		endcase
	endtask

	task automatic compare_output();
		res_t want;
		if (decoded_q.size() == 0) begin
			$error("unexpected output item: out_byte %02h run_last %0b string_end %0b",
				out_byte, run_last, string_end);
			mismatches++;
		end else begin
			want = decoded_q.pop_front();
			if (out_byte !== want.data) begin
				$error("out_byte: expected %02h, actual %02h", want.data, out_byte);
				mismatches++;
			end
			if (run_last !== want.run_last) begin
				$error("run_last: expected %0b, actual %0b", want.run_last, run_last);
				mismatches++;
			end
			if (string_end !== want.string_end) begin
				$error("string_end: expected %0b, actual %0b", want.string_end, string_end);
				mismatches++;
			end
		end
	endtask

	// Output first: an output item can never stem from the input item taken
	// at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_q.delete();
			esc_phase   = PH_IDLE;
			held_byte   = 8'd0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_output();
			if (in_valid && !in_stall)
				decode_expected(in_byte, in_last);
			outstanding = decoded_q.size();
		end
	end

endmodule

>>> tb/sv/tb_url_percent_decoder_core.sv
`timescale 1ns / 1ps

// Top of the decoder testbench. It makes the stimulus and stalls, and gives
// the verdict; the monitor beside the block does all prediction and checking.
module tb_url_percent_decoder_core;
	import urlpd_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;
	int         fails;
	int         pending;

	// The characters of the string that is being sent next.
	logic [7:0] text_q[$];
	int         items_sent = 0;
	// While one of these counts down, the matching side does not idle at all,
	// so that long unbroken stretches occur as well as scattered gaps.
	int         send_calm  = 0;
	int         recv_calm  = 0;

	url_percent_decoder_core uut (.*);

	urlpd_decode_monitor mon (
		.*,
		.fail_count   (fails),
		.pending_count(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit. The slowest correct run (every item after the longest gap,
	// two outputs per item each stalled for the longest wait) stays well below this.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Number of cycles one side waits before its next item.
	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// A random hex digit in either letter case.
	function automatic logic [7:0] hex_char();
		int n;
		n = $urandom_range(0, 21);
		if (n < 10)
			return 8'("0" + n);
		if (n < 16)
			return 8'("a" + n - 10);
		return 8'("A" + n - 16);
	endfunction

	// Presents one item and returns at the edge where it is taken. It is entered
	// at an edge, and in_valid is raised or left high there, never lowered and
	// raised in the same step. The stall is sampled at the falling edge, where
	// it already holds the value that the next rising edge will see.
	task automatic send_char(input logic [7:0] c, input logic last);
		int   gap;
		logic stalled;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		in_last  <= last;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		items_sent++;
	endtask

	// Sends the buffered string with the end mark on its final character.
	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic send_str(input string s);
		int i;
		text_q.delete();
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text();
	endtask

	// Drops in_valid and holds off until every expected output item has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// A random string built mostly from well-formed escapes with random hex
	// content, mixed with plain bytes, plus signs, and broken escapes ('%' with
	// only one or no character after it). A broken escape at the very end is
	// what makes the block flush a pending '%' and a held character.
	task automatic make_random_text();
		int target;
		int pick;
		target = $urandom_range(1, 14);
		text_q.delete();
		while (text_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				text_q.push_back(CH_PERCENT);
				text_q.push_back(hex_char());
				text_q.push_back(hex_char());
			end else if (pick < 75) begin
				text_q.push_back(8'($urandom_range(1, 255)));
			end else if (pick < 85) begin
				text_q.push_back(CH_PLUS);
			end else begin
				text_q.push_back(CH_PERCENT);
				if ($urandom_range(0, 1) != 0)
					text_q.push_back(8'($urandom_range(1, 255)));
			end
		end
	endtask

	// The receiver stalls for a random number of cycles before each output
	// item, then keeps out_stall low until one is taken.
	initial begin
		int   hold;
		logic seen;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = draw_wait(recv_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do begin
				@(negedge clk);
				seen = out_valid;
				@(posedge clk);
			end while (!seen);
		end
	end

	initial begin
		bit drained_once;
		drained_once = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h41;
		in_last  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the bytes 01 and FF, which between them set every bit
		// of in_byte and clear every bit but bit 0.
		text_q = '{8'h01, 8'hFF};
		send_text();
		// A plus sign and a lower-case escape.
		send_str("+%4a");
		// Hex first digit with a non-hex second one, closing the string, so
		// the decoded byte also carries the end mark.
		send_str("%Fz");
		// Non-hex first digit: the escape gives a zero byte.
		send_str("%q7");
		// Percent as the final character comes out literally.
		send_str("%");
		// A character held after '%' at string end: the '%' and then that
		// character, a plus sign turning into a space and a percent staying.
		send_str("%+");
		send_str("%%");
		send_str("%C");
		// Plain character ahead of an upper-case escape.
		send_str("x%D9");

		// Let the block run dry once before the random part starts.
		wait_drained();

		while (items_sent < 850) begin
			make_random_text();
			send_text();
			// Halfway through, the sender pauses once more until every
			// expected output item has arrived.
			if (!drained_once && items_sent >= 450) begin
				drained_once = 1'b1;
				wait_drained();
			end
		end

		// Wait until nothing is expected, then a few more cycles so that a
		// spurious output item would still be caught.
		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
